/* design/pim_pkg.sv */
// ----------------------------------------------------------------------------
// pim_pkg: shared types and constants for the priority inheritance mutex
// Field widths, status codes and the waiter queue entry layout.
// ----------------------------------------------------------------------------
package pim_pkg;

  localparam int TASK_W   = 4;
  localparam int PRIO_W   = 8;
  localparam int LEVEL_W  = 16;
  localparam int STATUS_W = 4;

  // default waiter queue depth
  localparam int DEFAULT_MAX_WAITERS = 16;

  // saturation point of the nesting counter
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_NESTED      = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_WOULD_BLOCK = 4'd3,
    ST_NOT_OWNER   = 4'd4,
    ST_NOT_STARTED = 4'd5,
    ST_NESTED_REL  = 4'd6,
    ST_FREED       = 4'd7,
    ST_HANDOFF     = 4'd8,
    ST_OVERFLOW    = 4'd9
  } status_e;

  // request opcodes
  localparam logic OP_PEND    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // one waiter queue entry
  typedef struct packed {
    logic [TASK_W-1:0] id;
    logic [PRIO_W-1:0] prio;
  } waiter_t;

  localparam int WAITER_W = $bits(waiter_t);

endpackage

/* design/pim_ram.sv */
// ----------------------------------------------------------------------------
// pim_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/priority_inheritance_mutex.sv */
// ----------------------------------------------------------------------------
// priority_inheritance_mutex: recursive mutex with priority inheritance
// Pend/release sequencer over a priority-sorted waiter queue held in RAM.
// ----------------------------------------------------------------------------
// One request is processed at a time. A request passes through transfer,
// decode and result load. A queued pend walks the waiter queue from its tail
// with one compare-and-shift step per cycle. Each waiter with a larger
// priority value is shifted up one slot, and the walk stops at the first
// waiter whose value is not larger or at the queue head; a full queue refuses
// the pend. A final release that hands the lock off reads the queue head from
// RAM. The queue is a circular buffer in a single-write, single-read RAM;
// that RAM port sets the insert step rate. The input side is stalled while a
// request is in work; a finished result sits in the output register, and a
// new request may be taken meanwhile. A result that finds the output register
// full and stalled waits in the final state. The configuration write port is
// always ready.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex import pim_pkg::*; #(
  parameter int MAX_WAITERS = DEFAULT_MAX_WAITERS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_os_running_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [TASK_W-1:0]   task_id_i,
  input  logic [PRIO_W-1:0]   task_prio_i,
  input  logic                may_wait_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                owner_valid_o,
  output logic [TASK_W-1:0]   owner_id_o,
  output logic [LEVEL_W-1:0]  nest_level_o,
  output logic                prio_change_o,
  output logic [TASK_W-1:0]   prio_task_o,
  output logic [PRIO_W-1:0]   prio_value_o,
  output logic                woken_valid_o,
  output logic [TASK_W-1:0]   woken_id_o
);

  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W = $clog2(MAX_WAITERS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_WAITERS);
  localparam logic [CNT_W:0]   SUM_WRAP = (CNT_W + 1)'(MAX_WAITERS);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_POP     = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  // queue position to RAM address (circular buffer)
  function automatic logic [IDX_W-1:0] slot_f(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, ofs};
    if (sum >= SUM_WRAP) begin
      sum = sum - SUM_WRAP;
    end
    return sum[IDX_W-1:0];
  endfunction

  // control state
  logic [2:0]         state_q, state_d;
  logic               os_run_q, os_run_d;
  logic               held_q, held_d;
  logic [TASK_W-1:0]  owner_q, owner_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [PRIO_W-1:0]  saved_q, saved_d;
  logic [PRIO_W-1:0]  eff_q, eff_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic               out_valid_q, out_valid_d;

  // request capture and work registers
  logic               op_q;
  logic [TASK_W-1:0]  tid_q;
  logic [PRIO_W-1:0]  tprio_q;
  logic               mayw_q;
  logic [CNT_W-1:0]   k_q, k_d;

  // staged result fields
  status_e            st_q, st_d;
  logic               pchg_q, pchg_d;
  logic [TASK_W-1:0]  ptask_q, ptask_d;
  logic [PRIO_W-1:0]  pval_q, pval_d;
  logic               wvalid_q, wvalid_d;
  logic [TASK_W-1:0]  wid_q, wid_d;

  // output register payload
  status_e            o_status_q;
  logic               o_owner_valid_q;
  logic [TASK_W-1:0]  o_owner_id_q;
  logic [LEVEL_W-1:0] o_level_q;
  logic               o_pchg_q;
  logic [TASK_W-1:0]  o_ptask_q;
  logic [PRIO_W-1:0]  o_pval_q;
  logic               o_wvalid_q;
  logic [TASK_W-1:0]  o_wid_q;

  // queue RAM signals
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [CNT_W-1:0]   rd_ofs;
  waiter_t            ram_wdata, ram_entry;
  logic [WAITER_W-1:0] ram_rdata;
  waiter_t            new_entry;

  logic in_xfer, out_xfer, out_load;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_q && !out_stall_i;
  assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign ram_entry = waiter_t'(ram_rdata);
  assign new_entry = '{id: tid_q, prio: tprio_q};
  assign ram_raddr = slot_f(head_q, rd_ofs);
  assign ram_waddr = slot_f(head_q, k_q);

  pim_ram #(
    .WIDTH (WAITER_W),
    .DEPTH (MAX_WAITERS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer and lock state update
  always_comb begin
    state_d     = state_q;
    os_run_d    = os_run_q;
    held_d      = held_q;
    owner_d     = owner_q;
    level_d     = level_q;
    saved_d     = saved_q;
    eff_d       = eff_q;
    count_d     = count_q;
    head_d      = head_q;
    k_d         = k_q;
    st_d        = st_q;
    pchg_d      = pchg_q;
    ptask_d     = ptask_q;
    pval_d      = pval_q;
    wvalid_d    = wvalid_q;
    wid_d       = wid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = new_entry;
    rd_ofs      = '0;
    out_valid_d = out_valid_q;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      os_run_d = cfg_os_running_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end

      // decode the request against the lock state
      S_EXEC: begin
        state_d  = S_FIN;
        pchg_d   = 1'b0;
        ptask_d  = '0;
        pval_d   = '0;
        wvalid_d = 1'b0;
        wid_d    = '0;
        if (!os_run_q) begin
          st_d = ST_NOT_STARTED;
        end else if (op_q == OP_PEND) begin
          if (!held_q) begin
            held_d  = 1'b1;
            owner_d = tid_q;
            saved_d = tprio_q;
            eff_d   = tprio_q;
            level_d = LEVEL_W'(1);
            st_d    = ST_GRANTED;
          end else if (owner_q == tid_q) begin
            if (level_q == LEVEL_MAX) begin
              st_d = ST_OVERFLOW;
            end else begin
              level_d = level_q + LEVEL_W'(1);
              st_d    = ST_NESTED;
            end
          end else if (!mayw_q) begin
            st_d = ST_WOULD_BLOCK;
          end else if (count_q == CNT_FULL) begin
            st_d = ST_OVERFLOW;
          end else begin
            // boost the owner if the caller is more urgent
            if (eff_q > tprio_q) begin
              eff_d   = tprio_q;
              pchg_d  = 1'b1;
              ptask_d = owner_q;
              pval_d  = tprio_q;
            end
            st_d = ST_QUEUED;
            k_d  = count_q;
            if (count_q == '0) begin
              state_d = S_INS_PUT;
            end else begin
              ram_re  = 1'b1;
              rd_ofs  = count_q - CNT_W'(1);
              state_d = S_INS_CMP;
            end
          end
        end else begin
          if (!held_q || level_q == '0 || owner_q != tid_q) begin
            st_d = ST_NOT_OWNER;
          end else if (level_q != LEVEL_W'(1)) begin
            level_d = level_q - LEVEL_W'(1);
            st_d    = ST_NESTED_REL;
          end else begin
            if (tprio_q != saved_q) begin
              pchg_d  = 1'b1;
              ptask_d = tid_q;
              pval_d  = saved_q;
            end
            if (count_q != '0) begin
              // fetch the head waiter; the level stays at one across the handoff
              ram_re  = 1'b1;
              rd_ofs  = '0;
              state_d = S_POP;
            end else begin
              held_d  = 1'b0;
              owner_d = '0;
              eff_d   = '0;
              level_d = '0;
              st_d    = ST_FREED;
            end
          end
        end
      end

      // one insertion step: shift the tail entry up while the caller is more urgent
      S_INS_CMP: begin
        if (tprio_q < ram_entry.prio) begin
          ram_we    = 1'b1;
          ram_wdata = ram_entry;
          k_d       = k_q - CNT_W'(1);
          if (k_q != CNT_W'(1)) begin
            ram_re = 1'b1;
            rd_ofs = k_q - CNT_W'(2);
          end else begin
            state_d = S_INS_PUT;
          end
        end else begin
          state_d = S_INS_PUT;
        end
      end

      // place the caller in the freed slot
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = new_entry;
        count_d   = count_q + CNT_W'(1);
        state_d   = S_FIN;
      end

      // hand the lock to the head waiter
      S_POP: begin
        rd_ofs   = CNT_W'(1);
        head_d   = ram_raddr;
        count_d  = count_q - CNT_W'(1);
        held_d   = 1'b1;
        owner_d  = ram_entry.id;
        level_d  = LEVEL_W'(1);
        saved_d  = ram_entry.prio;
        eff_d    = ram_entry.prio;
        wvalid_d = 1'b1;
        wid_d    = ram_entry.id;
        st_d     = ST_HANDOFF;
        state_d  = S_FIN;
      end

      // wait for room in the output register
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      os_run_q    <= 1'b0;
      held_q      <= 1'b0;
      owner_q     <= '0;
      level_q     <= '0;
      saved_q     <= '0;
      eff_q       <= '0;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      os_run_q    <= os_run_d;
      held_q      <= held_d;
      owner_q     <= owner_d;
      level_q     <= level_d;
      saved_q     <= saved_d;
      eff_q       <= eff_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture, work and staging registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= opcode_i;
      tid_q   <= task_id_i;
      tprio_q <= task_prio_i;
      mayw_q  <= may_wait_i;
    end
    k_q      <= k_d;
    st_q     <= st_d;
    pchg_q   <= pchg_d;
    ptask_q  <= ptask_d;
    pval_q   <= pval_d;
    wvalid_q <= wvalid_d;
    wid_q    <= wid_d;
  end

  // output register payload, loaded with the lock state after the request
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_status_q      <= st_q;
      o_owner_valid_q <= held_q;
      o_owner_id_q    <= held_q ? owner_q : '0;
      o_level_q       <= level_q;
      o_pchg_q        <= pchg_q;
      o_ptask_q       <= ptask_q;
      o_pval_q        <= pval_q;
      o_wvalid_q      <= wvalid_q;
      o_wid_q         <= wid_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign owner_valid_o = o_owner_valid_q;
  assign owner_id_o    = o_owner_id_q;
  assign nest_level_o  = o_level_q;
  assign prio_change_o = o_pchg_q;
  assign prio_task_o   = o_ptask_q;
  assign prio_value_o  = o_pval_q;
  assign woken_valid_o = o_wvalid_q;
  assign woken_id_o    = o_wid_q;

  // queue never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_FULL)
    else $error("waiter count above queue depth");

  // a held lock always has a nonzero nesting level, a free one a zero level
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q == (level_q != '0))
    else $error("lock held flag and nesting level disagree");

  // no task waits on a free lock
  assert property (@(posedge clk_i) disable iff (!rst_ni) !held_q |-> count_q == '0)
    else $error("waiters present while lock is free");

  // the insert walk never runs below the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_INS_CMP |-> k_q != '0)
    else $error("insert step with empty position");

  // an accepted request is decoded in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_xfer |=> state_q == S_EXEC)
    else $error("request transfer not followed by decode");

endmodule
